>>> sv/gre_pkg.sv
`default_nettype none

package gre_pkg;

  // Frame geometry.
  localparam int unsigned FrameLen  = 39;
  localparam int unsigned CsumSpan  = 34;
  localparam int unsigned HeaderLen = 6;
  localparam int unsigned CntW      = $clog2(FrameLen);

  // Fixed frame bytes.
  localparam logic [7:0] Header [HeaderLen] = '{8'h2B, 8'h52, 8'h52, 8'h43, 8'h42, 8'h7E};
  localparam logic [7:0] FrameLenByte = 8'd26;
  localparam logic [7:0] StarByte     = 8'h2A;
  localparam logic [7:0] CrByte       = 8'h0D;
  localparam logic [7:0] LfByte       = 8'h0A;

  // Flag bits.
  localparam logic [7:0] FlagValid  = 8'h80;
  localparam logic [7:0] FlagCourse = 8'h40;
  localparam logic [7:0] FlagEast   = 8'h20;
  localparam logic [7:0] FlagNorth  = 8'h10;

  // Speed scaling to knots: (speed * KnotMul) >> 24.
  localparam logic [19:0] KnotMul = 20'd905897;

  // 10^7 = 2^7 * 78125. Quotient of a 25-bit value by 78125 is
  // (x * DegMagic) >> 42, exact for every 25-bit x.
  localparam logic [16:0] DegLow   = 17'd78125;
  localparam logic [25:0] DegMagic = 26'd56294996;

  // Milli-minutes: rem * 6 / 1000 = ((rem * 3) >> 2) / 125, and the
  // division by 125 of a 23-bit value is (y * MinMagic) >> 30, exact.
  localparam logic [23:0] MinMagic = 24'd8589935;

  // One input record.
  typedef struct packed {
    logic [31:0] rec_time;
    logic [30:0] lat;
    logic [31:0] lon;
    logic [8:0]  cog;
    logic [15:0] spd;
  } rec_t;

  // Working set of the arithmetic pipeline. The a and b fields change
  // meaning from stage to stage as the division steps advance.
  typedef struct packed {
    logic        nz;
    logic [7:0]  flags;
    logic [7:0]  cog8;
    logic [15:0] spd;
    logic [7:0]  knots;
    logic [31:0] rec_time;
    logic [31:0] lon_a;
    logic [31:0] lat_a;
    logic [25:0] lon_b;
    logic [25:0] lat_b;
    logic [7:0]  lon_deg;
    logic [7:0]  lat_deg;
  } work_t;

  // One byte cell of the output chain.
  typedef struct packed {
    logic       valid;
    logic       last;
    logic [7:0] data;
  } cell_t;

  // Uppercase ASCII hex digit.
  function automatic logic [7:0] hex_digit(input logic [3:0] n);
    logic [7:0] base;
    base = (n > 4'd9) ? 8'd55 : 8'd48;
    return {4'h0, n} + base;
  endfunction

endpackage

`default_nettype wire

>>> sv/gre_cell.sv
`default_nettype none

module gre_cell (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           load_i,
  input  wire gre_pkg::cell_t load_cell_i,
  input  wire gre_pkg::cell_t next_i,
  output gre_pkg::cell_t      cell_o
);

  logic       valid_q, valid_d;
  logic       last_q, last_d;
  logic [7:0] data_q, data_d;

  // Take a fresh frame byte on load, otherwise the neighbor's contents.
  always_comb begin
    if (load_i) begin
      valid_d = load_cell_i.valid;
      last_d  = load_cell_i.last;
      data_d  = load_cell_i.data;
    end else begin
      valid_d = next_i.valid;
      last_d  = next_i.last;
      data_d  = next_i.data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    last_q <= last_d;
    data_q <= data_d;
  end

  assign cell_o = '{valid: valid_q, last: last_q, data: data_q};

endmodule

`default_nettype wire

>>> sv/gre_calc.sv
`default_nettype none

module gre_calc (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  input  wire gre_pkg::rec_t  rec_i,
  output logic                out_valid_o,
  output gre_pkg::work_t      out_o
);

  localparam int unsigned Stages = 7;

  logic [Stages-1:0] vld_q;
  gre_pkg::rec_t     rec_q;
  gre_pkg::work_t    s1_q, s1_d, s2_q, s2_d, s3_q, s3_d;
  gre_pkg::work_t    s4_q, s4_d, s5_q, s5_d, s6_q, s6_d;

  // Valid bits travel alongside the data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[Stages-2:0], in_valid_i};
    end
  end

  // Stage 1: magnitudes, flags and speed in knots.
  always_comb begin
    logic [31:0] lat_ext;
    logic [35:0] kn_full;
    lat_ext = {rec_q.lat[30], rec_q.lat};
    kn_full = 36'(rec_q.spd) * 36'(gre_pkg::KnotMul);
    s1_d          = '0;
    s1_d.nz       = (rec_q.lat != '0) && (rec_q.lon != '0);
    s1_d.flags    = gre_pkg::FlagValid
                  | (rec_q.cog[8]  ? gre_pkg::FlagCourse : 8'h00)
                  | (!rec_q.lon[31] ? gre_pkg::FlagEast  : 8'h00)
                  | (!rec_q.lat[30] ? gre_pkg::FlagNorth : 8'h00);
    s1_d.cog8     = rec_q.cog[7:0];
    s1_d.spd      = rec_q.spd;
    s1_d.knots    = (kn_full[35:32] != 4'h0) ? 8'hFF : kn_full[31:24];
    s1_d.rec_time = rec_q.rec_time;
    s1_d.lon_a    = rec_q.lon[31] ? (32'd0 - rec_q.lon) : rec_q.lon;
    s1_d.lat_a    = lat_ext[31] ? (32'd0 - lat_ext) : lat_ext;
  end

  // Stage 2: degrees as the quotient of the magnitude by 10^7.
  always_comb begin
    logic [50:0] lon_p, lat_p;
    lon_p = 51'(s1_q.lon_a[31:7]) * 51'(gre_pkg::DegMagic);
    lat_p = 51'(s1_q.lat_a[31:7]) * 51'(gre_pkg::DegMagic);
    s2_d         = s1_q;
    s2_d.lon_b   = 26'(lon_p[50:42]);
    s2_d.lat_b   = 26'(lat_p[50:42]);
    s2_d.lon_deg = lon_p[49:42];
    s2_d.lat_deg = lat_p[49:42];
  end

  // Stage 3: quotient times the odd part of 10^7.
  always_comb begin
    s3_d       = s2_q;
    s3_d.lon_b = 26'(s2_q.lon_b[8:0] * 26'(gre_pkg::DegLow));
    s3_d.lat_b = 26'(s2_q.lat_b[8:0] * 26'(gre_pkg::DegLow));
  end

  // Stage 4: remainder of the magnitude modulo 10^7.
  always_comb begin
    logic [24:0] lon_r, lat_r;
    lon_r      = s3_q.lon_a[31:7] - s3_q.lon_b[24:0];
    lat_r      = s3_q.lat_a[31:7] - s3_q.lat_b[24:0];
    s4_d       = s3_q;
    s4_d.lon_a = {8'h00, lon_r[16:0], s3_q.lon_a[6:0]};
    s4_d.lat_a = {8'h00, lat_r[16:0], s3_q.lat_a[6:0]};
  end

  // Stage 5: remainder times 3, divided by 4.
  always_comb begin
    logic [24:0] lon_t, lat_t;
    lon_t      = {1'b0, s4_q.lon_a[23:0]} + {s4_q.lon_a[23:0], 1'b0};
    lat_t      = {1'b0, s4_q.lat_a[23:0]} + {s4_q.lat_a[23:0], 1'b0};
    s5_d       = s4_q;
    s5_d.lon_a = {9'h000, lon_t[24:2]};
    s5_d.lat_a = {9'h000, lat_t[24:2]};
  end

  // Stage 6: divide by 125 to get milli-minutes.
  always_comb begin
    logic [46:0] lon_m, lat_m;
    lon_m      = 47'(s5_q.lon_a[22:0]) * 47'(gre_pkg::MinMagic);
    lat_m      = 47'(s5_q.lat_a[22:0]) * 47'(gre_pkg::MinMagic);
    s6_d       = s5_q;
    s6_d.lon_a = {16'h0000, lon_m[45:30]};
    s6_d.lat_a = {16'h0000, lat_m[45:30]};
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i) begin
      rec_q <= rec_i;
    end
    s1_q <= s1_d;
    s2_q <= s2_d;
    s3_q <= s3_d;
    s4_q <= s4_d;
    s5_q <= s5_d;
    s6_q <= s6_d;
  end

  assign out_valid_o = vld_q[Stages-1];
  assign out_o       = s6_q;

endmodule

`default_nettype wire

>>> sv/gps_record_frame_encoder.sv
`default_nettype none

// GPS record frame encoder.
// A record is requested by raising start while busy is low; the record
// fields are sampled at that clock edge. The block answers with a 39-byte
// telemetry frame, one byte per cycle on frame_byte_o, each marked by
// result_strobe_o for exactly one cycle. last_byte_o is high with the final
// LF byte. The receiver cannot stall; bytes leave in consecutive cycles.
// Path: each record passes a seven-stage arithmetic pipeline (magnitudes,
// two reciprocal divisions and their remainders) and is then loaded into a
// row of 39 byte cells that shifts one byte toward the output each cycle.
// The byte-wide output paces the records: a new record is accepted only
// while busy is low. busy stays high after a request while the frame
// counter runs down, so the next record enters while the previous frame
// is still shifting out.
// The station number is written through the cfg channel (always ready) and
// must only change while no frame is pending.
// Reset clears the station number, the busy counter and all valid bits.

module gps_record_frame_encoder (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [31:0] record_time_i,
  input  wire logic [30:0] latitude_i,
  input  wire logic [31:0] longitude_i,
  input  wire logic [8:0]  course_i,
  input  wire logic [15:0] speed_i,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [15:0] cfg_station_number_i,
  output logic             result_strobe_o,
  output logic [7:0]       frame_byte_o,
  output logic             last_byte_o
);

  localparam int unsigned N = gre_pkg::FrameLen;

  logic [15:0]              station_q;
  logic [gre_pkg::CntW-1:0] cnt_q, cnt_d;
  logic                     req;
  gre_pkg::rec_t            rec;
  logic                     ld_valid;
  gre_pkg::work_t           work;
  logic [7:0]               fb [N];
  gre_pkg::cell_t           load_cell [N];
  gre_pkg::cell_t           chain [N+1];

  // Configuration register.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      station_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      station_q <= cfg_station_number_i;
    end
  end

  // Request pacing: busy holds off requests until the frame counter runs out.
  assign req  = start && !busy;
  assign busy = (cnt_q != '0);

  always_comb begin
    cnt_d = cnt_q;
    if (req) begin
      cnt_d = gre_pkg::CntW'(N - 1);
    end else if (cnt_q != '0) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // Arithmetic pipeline.
  assign rec = '{rec_time: record_time_i, lat: latitude_i, lon: longitude_i,
                 cog: course_i, spd: speed_i};

  gre_calc u_calc (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req),
    .rec_i       (rec),
    .out_valid_o (ld_valid),
    .out_o       (work)
  );

  // Frame assembly with checksum over the leading bytes.
  always_comb begin
    logic [7:0] cs;
    for (int i = 0; i < N; i++) begin
      fb[i] = 8'h00;
    end
    for (int i = 0; i < gre_pkg::HeaderLen; i++) begin
      fb[i] = gre_pkg::Header[i];
    end
    fb[6]  = gre_pkg::FrameLenByte;
    fb[8]  = station_q[7:0];
    fb[9]  = station_q[15:8];
    fb[10] = work.rec_time[7:0];
    fb[11] = work.rec_time[15:8];
    fb[12] = work.rec_time[23:16];
    fb[13] = work.rec_time[31:24];
    if (work.nz) begin
      fb[14] = work.flags;
      fb[16] = work.lon_deg;
      fb[17] = work.lat_deg;
      fb[18] = work.lon_a[7:0];
      fb[19] = work.lon_a[15:8];
      fb[20] = work.lat_a[7:0];
      fb[21] = work.lat_a[15:8];
      fb[22] = work.knots;
      fb[23] = work.cog8;
    end
    cs = 8'h00;
    for (int i = 0; i < gre_pkg::CsumSpan; i++) begin
      cs = cs ^ fb[i];
    end
    fb[34] = gre_pkg::StarByte;
    fb[35] = gre_pkg::hex_digit(cs[7:4]);
    fb[36] = gre_pkg::hex_digit(cs[3:0]);
    fb[37] = gre_pkg::CrByte;
    fb[38] = gre_pkg::LfByte;
  end

  // Row of byte cells shifting toward cell 0.
  assign chain[N] = '0;

  for (genvar g = 0; g < N; g++) begin : g_cell
    assign load_cell[g] = '{valid: 1'b1, last: (g == N - 1), data: fb[g]};

    gre_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .load_i      (ld_valid),
      .load_cell_i (load_cell[g]),
      .next_i      (chain[g+1]),
      .cell_o      (chain[g])
    );
  end

  assign result_strobe_o = chain[0].valid;
  assign frame_byte_o    = chain[0].data;
  assign last_byte_o     = chain[0].valid && chain[0].last;

  // A new frame only loads when the previous one is down to its last byte.
  a_load_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ld_valid |-> !chain[1].valid)
    else $error("frame loaded over an unfinished frame");

  // A request is always followed by a busy period.
  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req |=> busy)
    else $error("busy not raised after request");

  // A byte that is not the last of its frame is always followed by another byte.
  a_last_then: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_strobe_o && !last_byte_o) |=> result_strobe_o)
    else $error("frame interrupted before its last byte");

endmodule

`default_nettype wire
